[src/pip_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants of the point-in-polygon test
// Sizes of the vertex chain, coordinate and product widths, request codes
// and the structs that pass between the top level and the edge evaluator.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W        = $clog2(MAX_VERTICES);

	localparam int MODE_W = 2;
	localparam int LAT_W  = 31;
	localparam int LON_W  = 32;
	localparam int DLAT_W = LAT_W + 1;
	localparam int DLON_W = LON_W + 1;
	localparam int PROD_W = DLAT_W + DLON_W + 1;

	// Pipeline depth of the edge evaluator, from request to hit flag.
	localparam int PIPE_DEPTH = 2;
	localparam int DRAIN_W    = $clog2(PIPE_DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	// Fewer stored vertices than this make no polygon.
	localparam int MIN_VERTICES = 3;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat;
		logic signed [LON_W-1:0] lon;
	} vertex_t;

	typedef struct packed {
		logic    valid;
		vertex_t a;
		vertex_t b;
	} edge_req_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} edge_hit_t;

endpackage
`default_nettype wire

[src/pip_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_cell: one link of the vertex chain
// Holds one vertex and takes its neighbor's vertex whenever the chain shifts.
// ----------------------------------------------------------------------------
module pip_cell (
	input  wire logic             clk,
	input  wire logic             shift_en,
	input  wire pip_pkg::vertex_t vtx_in,
	output pip_pkg::vertex_t      vtx_q
);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			vtx_q <= vtx_in;
		end
	end

endmodule
`default_nettype wire

[src/pip_edge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pip_edge: crossing test of one polygon edge
// Two-stage pipeline: differences and straddle check, then the two cross
// products; the compare against the sign of the latitude step gives the hit.
// ----------------------------------------------------------------------------
module pip_edge (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire pip_pkg::edge_req_t             req,
	input  wire logic signed [pip_pkg::LAT_W-1:0] py,
	input  wire logic signed [pip_pkg::LON_W-1:0] px,
	output pip_pkg::edge_hit_t                  res
);

	logic                               valid_s1;
	logic                               straddle_s1;
	logic signed [pip_pkg::DLAT_W-1:0]  d_s1;
	logic signed [pip_pkg::DLAT_W-1:0]  dyp_s1;
	logic signed [pip_pkg::DLON_W-1:0]  dxp_s1;
	logic signed [pip_pkg::DLON_W-1:0]  dxb_s1;

	logic                               valid_s2;
	logic                               straddle_s2;
	logic                               dpos_s2;
	logic signed [pip_pkg::PROD_W-1:0]  lhs_s2;
	logic signed [pip_pkg::PROD_W-1:0]  rhs_s2;

	logic straddle;

	assign straddle = ((req.a.lat <= py) && (req.b.lat > py)) ||
		((req.a.lat > py) && (req.b.lat <= py));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		straddle_s1 <= straddle;
		d_s1   <= pip_pkg::DLAT_W'(req.b.lat) - pip_pkg::DLAT_W'(req.a.lat);
		dyp_s1 <= pip_pkg::DLAT_W'(py) - pip_pkg::DLAT_W'(req.a.lat);
		dxp_s1 <= pip_pkg::DLON_W'(px) - pip_pkg::DLON_W'(req.a.lon);
		dxb_s1 <= pip_pkg::DLON_W'(req.b.lon) - pip_pkg::DLON_W'(req.a.lon);

		straddle_s2 <= straddle_s1;
		dpos_s2     <= (d_s1 > 0);
		lhs_s2      <= pip_pkg::PROD_W'(dxp_s1) * pip_pkg::PROD_W'(d_s1);
		rhs_s2      <= pip_pkg::PROD_W'(dyp_s1) * pip_pkg::PROD_W'(dxb_s1);
	end

	// A straddling edge never has a zero latitude step.
	assign res.valid = valid_s2;
	assign res.hit   = straddle_s2 && (dpos_s2 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2));

endmodule
`default_nettype wire

[src/point_in_polygon_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon test
// Stores a polygon of fixed-point vertices in a chain of cells and tests
// query points against it by rotating the chain through one edge evaluator.
// ----------------------------------------------------------------------------
// Each request carries a mode: append a vertex, clear the polygon, or query a
// point (a fourth code is taken and ignored). Append and clear give no result.
// A query against a polygon of three or more vertices passes through a full
// rotation of the chain, the closing edge, the drain of the evaluator
// pipeline and the load of the output register; with fewer than three
// vertices it goes straight to the load of the output register. The
// rotation streams one vertex per cycle into the single shared edge
// evaluator. While a query runs no new request is taken; a finished result
// waits in the output register, and appends and clears are taken meanwhile.
// Appends beyond the chain length are dropped and set a sticky overflow flag
// that a clear removes.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [pip_pkg::MODE_W-1:0]          mode,
	input  wire logic signed [pip_pkg::LAT_W-1:0]    latitude,
	input  wire logic signed [pip_pkg::LON_W-1:0]    longitude,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     inside_res,
	output logic                                     too_few_vertices,
	output logic                                     overflowed
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_CLOSE,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t                              state_q;
	logic [pip_pkg::COUNT_W-1:0]         count_q;
	logic                                overflow_q;
	logic [pip_pkg::IDX_W-1:0]           step_q;
	logic [pip_pkg::DRAIN_W-1:0]         drain_q;
	logic                                parity_q;
	logic                                few_q;
	logic                                out_valid_q;
	logic                                inside_q;
	logic                                out_few_q;
	logic                                out_ovf_q;

	// Query point and the running vertex pair, payload only.
	logic signed [pip_pkg::LAT_W-1:0]    qlat_q;
	logic signed [pip_pkg::LON_W-1:0]    qlon_q;
	pip_pkg::vertex_t                    prev_q;
	pip_pkg::vertex_t                    first_q;

	pip_pkg::vertex_t                    chain [pip_pkg::MAX_VERTICES];
	pip_pkg::vertex_t                    head_in;
	pip_pkg::vertex_t                    tail;
	pip_pkg::vertex_t                    new_vtx;
	logic                                shift_en;
	logic                                accept;
	logic                                do_append;
	logic [pip_pkg::COUNT_W:0]           pos;
	logic                                vtx_ok;
	logic                                vtx_first;
	pip_pkg::edge_req_t                  req;
	pip_pkg::edge_hit_t                  hit;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign do_append = accept && (mode == pip_pkg::MODE_APPEND) &&
		(count_q < pip_pkg::COUNT_W'(pip_pkg::MAX_VERTICES));

	assign new_vtx.lat = latitude;
	assign new_vtx.lon = longitude;

	// Appends shift the chain forward, so stored vertices sit newest first from
	// cell zero. A query rotates the chain once around its full length, which
	// brings the unused cells out first and then the vertices in stored order.
	assign tail     = chain[pip_pkg::MAX_VERTICES-1];
	assign shift_en = do_append || (state_q == ST_RUN);
	assign head_in  = (state_q == ST_RUN) ? tail : new_vtx;

	genvar gi;
	generate
		for (gi = 0; gi < pip_pkg::MAX_VERTICES; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				pip_cell u_cell (
					.clk      (clk),
					.shift_en (shift_en),
					.vtx_in   (head_in),
					.vtx_q    (chain[gi])
				);
			end else begin : g_link
				pip_cell u_cell (
					.clk      (clk),
					.shift_en (shift_en),
					.vtx_in   (chain[gi-1]),
					.vtx_q    (chain[gi])
				);
			end
		end
	endgenerate

	// The tail carries stored vertex number step + count - MAX_VERTICES once
	// that figure is not negative.
	assign pos       = (pip_pkg::COUNT_W + 1)'(step_q) + (pip_pkg::COUNT_W + 1)'(count_q);
	assign vtx_ok    = (pos >= (pip_pkg::COUNT_W + 1)'(pip_pkg::MAX_VERTICES));
	assign vtx_first = (pos == (pip_pkg::COUNT_W + 1)'(pip_pkg::MAX_VERTICES));

	// One edge per cycle: from the previous vertex to the tail during the
	// rotation, then the closing edge from the last vertex back to the first.
	always_comb begin
		req.valid = ((state_q == ST_RUN) && vtx_ok && !vtx_first) || (state_q == ST_CLOSE);
		req.a     = prev_q;
		req.b     = (state_q == ST_CLOSE) ? first_q : tail;
	end

	pip_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.py     (qlat_q),
		.px     (qlon_q),
		.res    (hit)
	);

	always_ff @(posedge clk) begin
		if (accept && (mode == pip_pkg::MODE_QUERY)) begin
			qlat_q <= latitude;
			qlon_q <= longitude;
		end
		if ((state_q == ST_RUN) && vtx_ok) begin
			prev_q <= tail;
			if (vtx_first) begin
				first_q <= tail;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			step_q      <= '0;
			drain_q     <= '0;
			parity_q    <= 1'b0;
			few_q       <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
			out_few_q   <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			if (hit.valid && hit.hit) begin
				parity_q <= ~parity_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							pip_pkg::MODE_APPEND: begin
								if (do_append) begin
									count_q <= count_q + 1'b1;
								end else begin
									overflow_q <= 1'b1;
								end
							end
							pip_pkg::MODE_CLEAR: begin
								count_q    <= '0;
								overflow_q <= 1'b0;
							end
							pip_pkg::MODE_QUERY: begin
								parity_q <= 1'b0;
								step_q   <= '0;
								if (count_q < pip_pkg::COUNT_W'(pip_pkg::MIN_VERTICES)) begin
									few_q   <= 1'b1;
									state_q <= ST_FIN;
								end else begin
									few_q   <= 1'b0;
									state_q <= ST_RUN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == pip_pkg::IDX_W'(pip_pkg::MAX_VERTICES - 1)) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					drain_q <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == pip_pkg::DRAIN_W'(pip_pkg::PIPE_DEPTH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						inside_q    <= parity_q && !few_q;
						out_few_q   <= few_q;
						out_ovf_q   <= overflow_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign inside_res       = inside_q;
	assign too_few_vertices = out_few_q;
	assign overflowed       = out_ovf_q;

endmodule
`default_nettype wire

[bench/pip_crossing_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_crossing_checker: prediction and comparison for the point-in-polygon test
// Follows every accepted request, keeps its own polygon, computes the
// crossing-number verdict of each query and compares it with the results.
// ----------------------------------------------------------------------------
module pip_crossing_checker
	import pip_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [LAT_W-1:0]  latitude,
	input  logic signed [LON_W-1:0]  longitude,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     inside_res,
	input  logic                     too_few_vertices,
	input  logic                     overflowed,
	output int                       mismatch_count,
	output int                       pending_results
);

	// Wide enough that every difference and product is exact.
	localparam int WIDE_W       = 80;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic in_poly;
		logic few;
		logic dropped;
	} verdict_t;

	logic signed [LAT_W-1:0] poly_lat [MAX_VERTICES];
	logic signed [LON_W-1:0] poly_lon [MAX_VERTICES];
	int                      poly_count;
	logic                    poly_dropped;
	verdict_t                expected_verdicts [$];
	int                      mismatches = 0;

	// True when edge a->b straddles latitude py and crosses it east of px.
	// The crossing longitude is compared after multiplying through by the
	// latitude difference, so its sign decides the direction of the test.
	function automatic logic edge_crosses_east(
		input logic signed [WIDE_W-1:0] ay, ax, by, bx, py, px);
		logic signed [WIDE_W-1:0] dlat, lhs, rhs;
		if (!((ay <= py && by > py) || (ay > py && by <= py)))
			return 1'b0;
		dlat = by - ay;
		lhs  = (px - ax) * dlat;
		rhs  = (py - ay) * (bx - ax);
		return (dlat > 0) ? (lhs < rhs) : (lhs > rhs);
	endfunction

	function automatic verdict_t classify_point(
		input logic signed [LAT_W-1:0] py,
		input logic signed [LON_W-1:0] px);
		verdict_t v;
		int       nxt;
		logic     parity;
		v.dropped = poly_dropped;
		parity    = 1'b0;
		if (poly_count < MIN_VERTICES) begin
			v.in_poly = 1'b0;
			v.few     = 1'b1;
			return v;
		end
		for (int i = 0; i < poly_count; i++) begin
			nxt = (i + 1 < poly_count) ? i + 1 : 0;
			if (edge_crosses_east(poly_lat[i], poly_lon[i], poly_lat[nxt], poly_lon[nxt],
					py, px))
				parity = ~parity;
		end
		v.in_poly = parity;
		v.few     = 1'b0;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			poly_count   = 0;
			poly_dropped = 1'b0;
			expected_verdicts.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = {inside_res, too_few_vertices, overflowed};
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result with no query waiting: inside=%0b few=%0b ovf=%0b",
							$time, got.in_poly, got.few, got.dropped);
				end else begin
					want = expected_verdicts.pop_front();
					if (got.in_poly !== want.in_poly || got.few !== want.few ||
							got.dropped !== want.dropped) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: mismatch: expected inside=%0b few=%0b ovf=%0b, got inside=%0b few=%0b ovf=%0b",
								$time, want.in_poly, want.few, want.dropped,
								got.in_poly, got.few, got.dropped);
					end
				end
			end
			if (in_valid && in_ready) begin
				case (mode)
					MODE_APPEND: begin
						if (poly_count < MAX_VERTICES) begin
							poly_lat[poly_count] = latitude;
							poly_lon[poly_count] = longitude;
							poly_count++;
						end else begin
							poly_dropped = 1'b1;
						end
					end
					MODE_CLEAR: begin
						poly_count   = 0;
						poly_dropped = 1'b0;
					end
					MODE_QUERY: begin
						expected_verdicts.push_back(classify_point(latitude, longitude));
					end
					default: begin
					end
				endcase
			end
		end
		pending_results <= expected_verdicts.size();
		mismatch_count  <= mismatches;
	end

endmodule

[bench/point_in_polygon_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb: testbench of the point-in-polygon test
// Drives append, clear and query requests with random pacing on both
// channels; a checker beside the block predicts every verdict.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;
	import pip_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 750;
	// Cycles the receiver refuses results in one long stretch of back-pressure.
	localparam int LONG_HOLD    = 300;
	// Cycles without any handshake before the run is declared hung. This leaves
	// a wide margin over a query, the long hold and the longest random gap.
	localparam int IDLE_LIMIT   = 4000;
	// Quiet time after the last result, to catch a stray extra result.
	localparam int DRAIN_CYCLES = MAX_VERTICES + 16;

	// The fourth mode code is accepted by the block and ignored.
	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

	localparam longint LAT_LEGAL = 900000000;
	localparam longint LON_LEGAL = 1800000000;
	localparam logic signed [LAT_W-1:0] LAT_MIN = {1'b1, {(LAT_W-1){1'b0}}};
	localparam logic signed [LAT_W-1:0] LAT_MAX = {1'b0, {(LAT_W-1){1'b1}}};
	localparam logic signed [LON_W-1:0] LON_MIN = {1'b1, {(LON_W-1){1'b0}}};
	localparam logic signed [LON_W-1:0] LON_MAX = {1'b0, {(LON_W-1){1'b1}}};

	// How the coordinates of one polygon and its queries are drawn.
	typedef enum int {
		BOX_RAW,     // any bit pattern, legal range or not
		BOX_TINY,    // a few units wide: coincident points and flat edges
		BOX_WORLD,   // the whole legal range
		BOX_REGION   // a patch of random size somewhere in the legal range
	} box_kind_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [MODE_W-1:0]       mode      = MODE_APPEND;
	logic signed [LAT_W-1:0] latitude  = '0;
	logic signed [LON_W-1:0] longitude = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    inside_res;
	logic                    too_few_vertices;
	logic                    overflowed;

	int   mismatch_count;
	int   pending_results;
	// Requests that do real work; ignored-mode requests are not counted.
	int   useful_items    = 0;
	int   holds_requested = 0;
	// While set, neither side inserts gaps: back-to-back traffic.
	logic calm            = 1'b0;
	int   idle_cycles;

	always #(CLK_PERIOD / 2) clk = ~clk;

	point_in_polygon_test dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.latitude         (latitude),
		.longitude        (longitude),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inside_res       (inside_res),
		.too_few_vertices (too_few_vertices),
		.overflowed       (overflowed)
	);

	pip_crossing_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.latitude         (latitude),
		.longitude        (longitude),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.inside_res       (inside_res),
		.too_few_vertices (too_few_vertices),
		.overflowed       (overflowed),
		.mismatch_count   (mismatch_count),
		.pending_results  (pending_results)
	);

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one request and returns at the falling edge after it is taken.
	// Inputs change only at falling edges; the handshake is judged at the
	// rising edge. With no gap, valid simply stays high for the next request.
	task automatic send_request(input logic [MODE_W-1:0] m,
		input logic signed [LAT_W-1:0] la, input logic signed [LON_W-1:0] lo);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		latitude  <= la;
		longitude <= lo;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (m != MODE_IGNORED)
			useful_items++;
		@(negedge clk);
	endtask

	function automatic vertex_t box_point(input box_kind_t kind,
		input longint c_lat, input longint c_lon, input longint s_lat, input longint s_lon);
		vertex_t p;
		if (kind == BOX_RAW) begin
			p.lat = LAT_W'($urandom);
			p.lon = $urandom;
		end else begin
			p.lat = LAT_W'(c_lat - s_lat + longint'($urandom_range(0, 32'(2 * s_lat))));
			p.lon = LON_W'(c_lon - s_lon + longint'($urandom_range(0, 32'(2 * s_lon))));
		end
		return p;
	endfunction

	// One polygon: usually a clear, then its vertices, then a few queries
	// aimed at the polygon's area. Query latitudes often equal a vertex
	// latitude, and some queries sit exactly on a vertex, to hit the
	// straddle boundaries. Flat edges come from repeating a latitude.
	task automatic run_polygon_case(input int case_idx);
		box_kind_t kind;
		longint    c_lat, c_lon, s_lat, s_lon;
		vertex_t   pts [$];
		vertex_t   p;
		int        n_vert, n_query, r;
		calm = ($urandom_range(0, 5) == 0);
		r = $urandom_range(0, 9);
		c_lat = longint'($urandom_range(0, 32'(2 * LAT_LEGAL))) - LAT_LEGAL;
		c_lon = longint'($urandom_range(0, 32'(2 * LON_LEGAL))) - LON_LEGAL;
		if (r == 0) begin
			kind = BOX_RAW;
		end else if (r <= 2) begin
			kind  = BOX_TINY;
			s_lat = $urandom_range(0, 4);
			s_lon = $urandom_range(0, 4);
		end else if (r == 3) begin
			kind  = BOX_WORLD;
			c_lat = 0;
			c_lon = 0;
			s_lat = LAT_LEGAL;
			s_lon = LON_LEGAL;
		end else begin
			kind  = BOX_REGION;
			s_lat = $urandom_range(10, 200000);
			s_lon = $urandom_range(10, 200000);
		end

		// Mostly small polygons; some degenerate ones, and some that run
		// past the store so that vertices are dropped.
		r = $urandom_range(0, 19);
		if (r == 0)
			n_vert = $urandom_range(0, 2);
		else if (r == 1)
			n_vert = $urandom_range(MAX_VERTICES - 2, MAX_VERTICES + 6);
		else
			n_vert = $urandom_range(3, 12);
		if (case_idx % 10 == 3)
			n_vert = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4);

		// Now and then the old polygon is kept and grown instead.
		if ($urandom_range(0, 6) != 0)
			send_request(MODE_CLEAR, LAT_W'($urandom), $urandom);

		for (int i = 0; i < n_vert; i++) begin
			p = box_point(kind, c_lat, c_lon, s_lat, s_lon);
			if (pts.size() > 0 && $urandom_range(0, 4) == 0)
				p.lat = pts[$].lat;
			send_request(MODE_APPEND, p.lat, p.lon);
			pts.push_back(p);
		end

		n_query = $urandom_range(1, 6);
		for (int q = 0; q < n_query; q++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				send_request(MODE_IGNORED, LAT_W'($urandom), $urandom);
			p = box_point(kind, c_lat, c_lon, s_lat, s_lon);
			if (pts.size() > 0 && r < 6)
				p.lat = pts[$urandom_range(0, pts.size() - 1)].lat;
			if (pts.size() > 0 && r == 6)
				p = pts[$urandom_range(0, pts.size() - 1)];
			send_request(MODE_QUERY, p.lat, p.lon);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int start_items;
		int case_idx;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Queries against an empty, a one-vertex and a
		// two-vertex polygon must all report too few vertices.
		send_request(MODE_QUERY, '0, '0);
		send_request(MODE_APPEND, LAT_MIN, LON_MIN);
		send_request(MODE_QUERY, '0, '0);
		send_request(MODE_APPEND, LAT_MAX, LON_MAX);
		send_request(MODE_QUERY, LAT_MAX, LON_MIN);
		// An ignored request must leave the polygon untouched.
		send_request(MODE_IGNORED, LAT_MAX, -1);
		// Third vertex at the opposite corner makes a triangle spanning
		// every bit pattern extreme; the products are at their largest here.
		send_request(MODE_APPEND, LAT_MAX, LON_MIN);
		send_request(MODE_QUERY, '0, '0);
		send_request(MODE_QUERY, LAT_MIN, LON_MIN);
		send_request(MODE_QUERY, LAT_MAX, LON_MAX);
		send_request(MODE_QUERY, LAT_MAX - 1, LON_MIN + 1);
		send_request(MODE_CLEAR, '0, '0);
		send_request(MODE_QUERY, '0, '0);

		// The legal-range rectangle: its top and bottom edges are flat, and
		// queries on its boundary test the half-open straddle rule.
		send_request(MODE_APPEND, -LAT_W'(LAT_LEGAL), -LON_W'(LON_LEGAL));
		send_request(MODE_APPEND, -LAT_W'(LAT_LEGAL), LON_W'(LON_LEGAL));
		send_request(MODE_APPEND, LAT_W'(LAT_LEGAL), LON_W'(LON_LEGAL));
		send_request(MODE_APPEND, LAT_W'(LAT_LEGAL), -LON_W'(LON_LEGAL));
		send_request(MODE_QUERY, '0, '0);
		send_request(MODE_QUERY, LAT_W'(LAT_LEGAL), '0);
		send_request(MODE_QUERY, -LAT_W'(LAT_LEGAL), '0);
		send_request(MODE_QUERY, '0, LON_W'(LON_LEGAL));
		send_request(MODE_QUERY, '0, -LON_W'(LON_LEGAL));
		send_request(MODE_QUERY, '0, LON_W'(LON_LEGAL - 1));
		send_request(MODE_IGNORED, LAT_MIN, LON_MAX);

		// Random part. The receiver starts a long hold right away, so the
		// first query result sits in the output register and the next query
		// stalls the input; a second hold comes later in the run.
		holds_requested++;
		start_items = useful_items;
		case_idx    = 0;
		while (useful_items - start_items < RANDOM_ITEMS) begin
			run_polygon_case(case_idx);
			case_idx++;
			if (case_idx == 25)
				holds_requested++;
		end
		calm     = 1'b0;
		in_valid <= 1'b0;

		wait (pending_results == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random stalls between bursts of readiness, and a long hold
	// whenever the stimulus asks for one. The hold is timed here, in cycles,
	// independently of what the sender is doing.
	initial begin
		int stall;
		int holds_done;
		holds_done = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (holds_done < holds_requested) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	// Watchdog: too long without a handshake on either channel means a hang.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
